### hdl/evws_pkg.sv
`timescale 1ns / 1ps
package evws_pkg;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_SAMPLE  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [23:0] interval;
    logic        wopen;
  } cmd_t;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [0:0] REG_WINDOW_SECONDS = 1'b0;
  localparam logic [11:0] WINDOW_RESET = 12'd5;
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  localparam logic [23:0] INTERVAL_MAX = 24'hFFFFFF;

endpackage

### hdl/event_interval_welford_stats.sv
`timescale 1ns / 1ps
// Channel   Direction  Transfer                 Payload
// in_       slave      in_tvalid & in_tready    tdata: timestamp_us, event_type; tuser: func
// out_      master     out_tvalid & out_tready  tdata: stats; tuser: interval_valid, window_open
// cfg_      APB slave  psel & penable & pwrite  register 0: window_seconds
//
// The front takes one item per cycle into a four-entry queue while it has room.
// A restart or a non-counted item goes straight to the output; a sample passes through the
// bit-serial mean divider and the shift-add multiplier, both MW bits wide, MW being the
// larger of 24+FRAC_BITS and 32, then the 64-bit variance divider once at least two samples
// are counted; these run one after another.
// Reset is synchronous and active low; out_tready low holds the result and the back.
module event_interval_welford_stats #(
  parameter int FRAC_BITS  = 8,
  parameter int COUNT_BITS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // timestamp_us[31:0], event_type[47:32]
  input  logic         in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  // sample_count[19:0], mean_interval[51:20], variance[115:52], last_interval_us[139:116]
  output logic [143:0] out_tdata,
  output logic [1:0]   out_tuser,  // interval_valid[0], window_open[1]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [0:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_nonempty;
  evws_pkg::cmd_t f_cmd;
  evws_pkg::cmd_t b_cmd;

  assign cfg_pready = 1'b1;

  evws_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .q_full(q_full), .q_push(q_push), .q_cmd(f_cmd)
  );

  evws_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wr_cmd(f_cmd), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .rd_cmd(b_cmd)
  );

  evws_back #(
    .FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_nonempty(q_nonempty), .q_cmd(b_cmd), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  a_valid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[0] || out_tuser[1]))
    else $error("sample reported with window closed");

  a_interval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[139:116] == 24'd0))
    else $error("interval nonzero without a sample");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

### hdl/evws_front.sv
`timescale 1ns / 1ps
module evws_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,
  input  logic              in_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [0:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  input  logic              q_full,
  output logic              q_push,
  output evws_pkg::cmd_t    q_cmd
);

  logic [11:0] wsec_r;
  logic [31:0] wstart_r;
  logic        active_r;
  logic        awaiting_r;
  logic [31:0] prev_r;

  logic [31:0] limit;
  logic [31:0] ts;
  logic [15:0] etype;
  logic        accept;
  logic [31:0] elapsed;
  logic [31:0] ivl;
  logic        qualify;

  assign ts        = in_tdata[31:0];
  assign etype     = in_tdata[47:32];
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign elapsed   = ts - wstart_r;
  assign ivl       = ts - prev_r;
  assign qualify   = etype inside {[16'd1:16'd3]};
  assign cfg_prdata = {20'd0, wsec_r};
  // The largest window, 4095 seconds, still fits in 32 bits of microseconds.
  assign limit     = 32'(wsec_r) * 32'(evws_pkg::US_PER_SEC);

  always_comb begin
    q_cmd.kind     = evws_pkg::CMD_NONE;
    q_cmd.interval = '0;
    q_cmd.wopen    = active_r;
    if (in_tuser) begin
      q_cmd.kind  = evws_pkg::CMD_RESTART;
      q_cmd.wopen = (wsec_r != 12'd0);
    end else if (active_r) begin
      if (elapsed >= limit) begin
        q_cmd.wopen = 1'b0;
      end else if (qualify && !awaiting_r) begin
        q_cmd.kind     = evws_pkg::CMD_SAMPLE;
        q_cmd.interval = (ivl > 32'(evws_pkg::INTERVAL_MAX)) ?
                         evws_pkg::INTERVAL_MAX : ivl[23:0];
      end
    end
  end

  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsec_r     <= evws_pkg::WINDOW_RESET;
      wstart_r   <= '0;
      active_r   <= 1'b0;
      awaiting_r <= 1'b1;
      prev_r     <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite &&
          cfg_paddr == evws_pkg::REG_WINDOW_SECONDS) begin
        wsec_r <= cfg_pwdata[11:0];
      end
      if (accept) begin
        if (in_tuser) begin
          wstart_r   <= ts;
          active_r   <= (wsec_r != 12'd0);
          awaiting_r <= 1'b1;
          prev_r     <= '0;
        end else if (active_r) begin
          if (elapsed >= limit) begin
            active_r <= 1'b0;
          end else if (qualify) begin
            awaiting_r <= 1'b0;
            prev_r     <= ts;
          end
        end
      end
    end
  end

endmodule

### hdl/evws_queue.sv
`timescale 1ns / 1ps
module evws_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  evws_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output evws_pkg::cmd_t rd_cmd
);

  evws_pkg::cmd_t               mem_r [evws_pkg::QDEPTH];
  logic [evws_pkg::QAW-1:0]     wp_r;
  logic [evws_pkg::QAW-1:0]     rp_r;
  logic [evws_pkg::QAW:0]       cnt_r;

  assign full     = (cnt_r == (evws_pkg::QAW+1)'(evws_pkg::QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign rd_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= wr_cmd;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && nonempty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (evws_pkg::QAW+1)'(push && !full)
                     - (evws_pkg::QAW+1)'(pop && nonempty);
    end
  end

endmodule

### hdl/evws_back.sv
`timescale 1ns / 1ps
module evws_back #(
  parameter int FRAC_BITS  = 8,
  parameter int COUNT_BITS = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nonempty,
  input  evws_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [143:0]   out_tdata,
  output logic [1:0]     out_tuser
);

  localparam int DW = 24 + FRAC_BITS;
  localparam int MW = (DW > 32) ? DW : 32;
  localparam int PW = 2 * MW;
  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MDIV, S_MEAN, S_D2, S_MUL, S_M2, S_VLD, S_VDIV, S_OUT
  } state_t;

  state_t         state_r;
  evws_pkg::cmd_t cmd_r;
  logic [CW-1:0]  cnt_r;
  logic [31:0]    mean_r;
  logic [63:0]    m2_r;
  logic [63:0]    var_r;
  logic [MW-1:0]  x_r;
  logic [MW-1:0]  dmag_r;
  logic           dpos_r;
  logic           keep_r;
  logic [63:0]    num_r;
  logic [CW-1:0]  rem_r;
  logic [CW-1:0]  dvs_r;
  logic [6:0]     step_r;
  logic [PW-1:0]  acc_r;
  logic [PW-1:0]  mc_r;
  logic [MW-1:0]  mp_r;
  logic           ov_r;
  logic [143:0]   odata_r;
  logic [1:0]     ouser_r;

  logic [CW:0]    rem_sh;
  logic           ge;
  logic [CW:0]    rem_sub;
  logic [MW-1:0]  mean_ext;
  logic [MW-1:0]  xin;
  logic [MW:0]    msum;
  logic [MW-1:0]  mdiff;
  logic [MW-1:0]  quo;
  logic           d2pos;
  logic [MW-1:0]  d2mag;
  logic [PW+63:0] pext;
  logic [63:0]    term;
  logic [64:0]    m2sum;

  assign rem_sh   = {rem_r, num_r[63]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign mean_ext = MW'(mean_r);
  assign xin      = MW'(q_cmd.interval) << FRAC_BITS;
  assign quo      = num_r[MW-1:0];
  assign msum     = {1'b0, mean_ext} + {1'b0, quo};
  assign mdiff    = mean_ext - quo;
  assign d2pos    = x_r >= mean_ext;
  assign d2mag    = d2pos ? (x_r - mean_ext) : (mean_ext - x_r);
  assign pext     = {64'd0, acc_r} >> FRAC_BITS;
  assign term     = !keep_r ? 64'd0 : ((|pext[PW+63:64]) ? '1 : pext[63:0]);
  assign m2sum    = {1'b0, m2_r} + {1'b0, term};

  assign q_pop      = (state_r == S_IDLE) && q_nonempty;
  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      mean_r  <= '0;
      m2_r    <= '0;
      var_r   <= '0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_nonempty) begin
            cmd_r <= q_cmd;
            case (q_cmd.kind)
              evws_pkg::CMD_RESTART: begin
                cnt_r   <= '0;
                mean_r  <= '0;
                m2_r    <= '0;
                var_r   <= '0;
                state_r <= S_OUT;
              end
              evws_pkg::CMD_SAMPLE: begin
                if (cnt_r != CMAX) cnt_r <= cnt_r + 1'b1;
                x_r     <= xin;
                state_r <= S_PREP;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_PREP: begin
          dpos_r  <= (x_r >= mean_ext);
          dmag_r  <= (x_r >= mean_ext) ? (x_r - mean_ext) : (mean_ext - x_r);
          num_r   <= 64'((x_r >= mean_ext) ? (x_r - mean_ext) : (mean_ext - x_r))
                     << (64 - MW);
          rem_r   <= '0;
          dvs_r   <= cnt_r;
          step_r  <= 7'(MW);
          state_r <= S_MDIV;
        end
        S_MDIV, S_VDIV: begin
          // Restoring division, one quotient bit per cycle.
          rem_r  <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
          num_r  <= {num_r[62:0], ge};
          step_r <= step_r - 1'b1;
          if (step_r == 7'd1) begin
            state_r <= (state_r == S_MDIV) ? S_MEAN : S_OUT;
            if (state_r == S_VDIV) var_r <= {num_r[62:0], ge};
          end
        end
        S_MEAN: begin
          if (dpos_r) mean_r <= (|msum[MW:32]) ? 32'hFFFFFFFF : msum[31:0];
          else mean_r <= mdiff[31:0];
          state_r <= S_D2;
        end
        S_D2: begin
          keep_r  <= (d2mag == '0) || (dmag_r == '0) || (dpos_r == d2pos);
          acc_r   <= '0;
          mc_r    <= PW'(dmag_r);
          mp_r    <= d2mag;
          step_r  <= 7'(MW);
          state_r <= S_MUL;
        end
        S_MUL: begin
          // Shift-add multiply, one multiplier bit per cycle.
          if (mp_r[0]) acc_r <= acc_r + mc_r;
          mc_r   <= {mc_r[PW-2:0], 1'b0};
          mp_r   <= {1'b0, mp_r[MW-1:1]};
          step_r <= step_r - 1'b1;
          if (step_r == 7'd1) state_r <= S_M2;
        end
        S_M2: begin
          m2_r    <= m2sum[64] ? '1 : m2sum[63:0];
          state_r <= S_VLD;
        end
        S_VLD: begin
          if (cnt_r >= CW'(2)) begin
            num_r   <= m2_r;
            rem_r   <= '0;
            dvs_r   <= cnt_r - 1'b1;
            step_r  <= 7'd64;
            state_r <= S_VDIV;
          end else begin
            var_r   <= '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ov_r || out_tready) begin
            ov_r    <= 1'b1;
            odata_r <= {4'd0, cmd_r.interval, var_r, mean_r, 20'(cnt_r)};
            ouser_r <= {cmd_r.wopen, cmd_r.kind == evws_pkg::CMD_SAMPLE};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/evws_checker.sv
`timescale 1ns / 1ps
module evws_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [47:0]  in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [143:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [0:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           stats_waiting
);

  localparam int FRAC = 8;
  localparam logic [63:0] COUNT_MAX = (64'd1 << 20) - 1;

  typedef struct packed {
    logic [19:0] count;
    logic [31:0] mean;
    logic [63:0] var_q;
    logic [23:0] last;
    logic        valid;
    logic        wopen;
  } stats_t;

  stats_t      pending_stats[$];
  logic [63:0] win_sec;
  logic [31:0] win_start;
  logic        win_active;
  logic        awaiting;
  logic [31:0] prev_ts;
  logic [63:0] sample_cnt;
  logic [63:0] mean_acc;
  logic [63:0] m2_acc;

  assign stats_waiting = pending_stats.size();

  // Welford update with the sign of each difference kept apart from its magnitude.
  task automatic add_interval(input logic [63:0] ivl);
    logic [63:0]  x, dmag, d2mag, stp, nm, term;
    logic [127:0] prod;
    logic         dpos, d2pos;
    if (sample_cnt < COUNT_MAX) sample_cnt++;
    x = ivl << FRAC;
    dpos = x >= mean_acc;
    dmag = dpos ? x - mean_acc : mean_acc - x;
    stp = dmag / sample_cnt;
    if (dpos) begin
      nm = mean_acc + stp;
      if (nm > 64'hFFFF_FFFF) nm = 64'hFFFF_FFFF;
    end else begin
      nm = mean_acc - stp;
    end
    mean_acc = nm;
    d2pos = x >= mean_acc;
    d2mag = d2pos ? x - mean_acc : mean_acc - x;
    if (d2mag == 0 || dmag == 0 || dpos == d2pos) begin
      prod = dmag * d2mag;
      prod = prod >> FRAC;
      term = (prod[127:64] != 0) ? '1 : prod[63:0];
    end else begin
      term = 0;
    end
    m2_acc = (m2_acc > ~64'd0 - term) ? '1 : m2_acc + term;
  endtask

  task automatic predict_stats(input logic func, input logic [31:0] ts, input logic [15:0] et);
    stats_t      e;
    logic [31:0] el32, d32;
    logic [63:0] ivl;
    e = '0;
    ivl = 0;
    if (func) begin
      win_start = ts;
      win_active = (win_sec != 0);
      awaiting = 1'b1;
      prev_ts = 0;
      sample_cnt = 0;
      mean_acc = 0;
      m2_acc = 0;
    end else if (win_active) begin
      el32 = ts - win_start;
      if ({32'd0, el32} >= win_sec * 64'd1000000) begin
        win_active = 1'b0;
      end else if (et >= 16'd1 && et <= 16'd3) begin
        if (awaiting) begin
          awaiting = 1'b0;
        end else begin
          d32 = ts - prev_ts;
          ivl = (d32 > {8'd0, evws_pkg::INTERVAL_MAX}) ?
                {40'd0, evws_pkg::INTERVAL_MAX} : {32'd0, d32};
          add_interval(ivl);
          e.valid = 1'b1;
        end
        prev_ts = ts;
      end
    end
    e.count = sample_cnt[19:0];
    e.mean = mean_acc[31:0];
    e.var_q = (sample_cnt >= 2) ? m2_acc / (sample_cnt - 1) : 64'd0;
    e.last = ivl[23:0];
    e.wopen = win_active;
    pending_stats.push_back(e);
  endtask

  always @(posedge clk) begin
    stats_t e, a;
    if (!rst_n) begin
      win_sec = {52'd0, evws_pkg::WINDOW_RESET};
      win_start = 0;
      win_active = 1'b0;
      awaiting = 1'b1;
      prev_ts = 0;
      sample_cnt = 0;
      mean_acc = 0;
      m2_acc = 0;
      fail_count <= 0;
      pending_stats.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        a.count = out_tdata[19:0];
        a.mean = out_tdata[51:20];
        a.var_q = out_tdata[115:52];
        a.last = out_tdata[139:116];
        a.valid = out_tuser[0];
        a.wopen = out_tuser[1];
        if (pending_stats.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer: %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = pending_stats.pop_front();
          if (a !== e) begin
            if (fail_count < 10) begin
              $display("mismatch count exp %0d act %0d, mean exp %h act %h",
                       e.count, a.count, e.mean, a.mean);
              $display("  variance exp %h act %h, last exp %0d act %0d",
                       e.var_q, a.var_q, e.last, a.last);
              $display("  valid exp %b act %b, window_open exp %b act %b",
                       e.valid, a.valid, e.wopen, a.wopen);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr == evws_pkg::REG_WINDOW_SECONDS)
        win_sec = {52'd0, cfg_pwdata[11:0]};
      if (in_tvalid && in_tready)
        predict_stats(in_tuser, in_tdata[31:0], in_tdata[47:32]);
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 1500000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [0:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           fail_count;
  int           stats_waiting;
  int           cycles = 0;
  logic         steady = 1'b0;
  logic [31:0]  now_us = 0;

  event_interval_welford_stats u_dut (.*);

  evws_checker u_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The result side stalls on its own schedule.
  initial begin
    int g;
    forever begin
      @(posedge clk);
      g = pick_gap();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (g - 1) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic func, input logic [31:0] ts, input logic [15:0] et);
    int g;
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {et, ts};
    do @(posedge clk); while (!in_tready);
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (stats_waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [11:0] secs);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= evws_pkg::REG_WINDOW_SECONDS;
    cfg_pwdata <= {20'd0, secs};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [31:0] time_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return $urandom_range(0, 5000);
    if (r < 96) return $urandom_range(5000, 200000);
    if (r < 99) return $urandom_range(0, 32'h0200_0000);
    return $urandom();
  endfunction

  task automatic random_items(input int num);
    int r;
    logic [15:0] et;
    repeat (num) begin
      r = $urandom_range(0, 99);
      now_us = now_us + time_step();
      if (r < 6) begin
        if ($urandom_range(0, 3) == 0) now_us = $urandom();
        send_item(1'b1, now_us, 16'($urandom()));
      end else begin
        et = (r < 14) ? 16'($urandom()) : 16'($urandom_range(1, 3));
        send_item(1'b0, now_us, et);
      end
    end
  endtask

  initial begin
    logic [11:0] secs [6];
    secs = '{12'd1, 12'd3600, 12'd4095, 12'd2, 12'd0, 12'd5};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Window closed after reset, then wrap, ignored types and the window closing at its limit.
    steady = 1'b1;
    send_item(1'b0, 32'd100, 16'd1);
    send_item(1'b1, 32'hFFFF_FFF0, 16'hFFFF);
    send_item(1'b0, 32'hFFFF_FFF8, 16'd0);
    send_item(1'b0, 32'hFFFF_FFFA, 16'd1);
    send_item(1'b0, 32'h0000_0010, 16'd2);
    send_item(1'b0, 32'h0000_0010, 16'd3);
    send_item(1'b0, 32'h0000_0020, 16'd4);
    send_item(1'b0, 32'h0000_0030, 16'hFFFF);
    send_item(1'b0, 32'h0040_0000, 16'd1);
    send_item(1'b0, 32'h0040_0100, 16'd3);
    send_item(1'b0, 32'h0050_0000, 16'h8000);
    send_item(1'b0, 32'h0050_0001, 16'd2);
    send_item(1'b1, 32'd0, 16'd0);
    send_item(1'b0, 32'd4999999, 16'd1);
    send_item(1'b0, 32'd5000000, 16'd2);
    send_item(1'b0, 32'd5000010, 16'd1);
    steady = 1'b0;
    drain();

    write_window(12'd0);
    send_item(1'b1, 32'h1234_5678, 16'd1);
    send_item(1'b0, 32'h1234_5679, 16'd1);
    send_item(1'b0, 32'h1234_5680, 16'd2);

    random_items(250);
    drain();
    foreach (secs[i]) begin
      write_window(secs[i]);
      send_item(1'b1, now_us, 16'd1);
      if (i == 2) steady = 1'b1;
      random_items(200);
      steady = 1'b0;
    end

    drain();
    repeat (150) @(posedge clk);
    if (fail_count == 0 && stats_waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/evws_pkg.sv
hdl/evws_front.sv
hdl/evws_queue.sv
hdl/evws_back.sv
hdl/event_interval_welford_stats.sv
tb/evws_checker.sv
tb/tb.sv
